// File: design/sha256_pkg.sv
package sha256_pkg;

    // Eight 32-bit words, index 0 is word a / H0.
    typedef logic [7:0][31:0] t_words;

    // Initial hash values, listed from H7 down to H0.
    localparam t_words H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;

endpackage

// File: design/sha256_in_if.sv
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

// File: design/sha256_out_if.sv
interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    modport source (output valid, output digest_word, output word_number,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_number,
                  input last_word, output ready);
endinterface

// File: design/sha256_round.sv
module sha256_round (
    input  sha256_pkg::t_words i_vars,
    input  logic [31:0]        i_k,
    input  logic [511:0]       i_win,
    output sha256_pkg::t_words o_vars,
    output logic [31:0]        o_sched
);

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        f_bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        f_bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        f_ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        f_ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    logic [31:0] w0, w1, w9, w14;
    logic [31:0] t1, t2;
    logic [31:0] a, b, c, d, e, f, g, h;

    // The window holds W[r] .. W[r+15], oldest word in the top bits.
    assign w0  = i_win[511:480];
    assign w1  = i_win[479:448];
    assign w9  = i_win[223:192];
    assign w14 = i_win[63:32];

    assign o_sched = f_ssig1(w14) + w9 + f_ssig0(w1) + w0;

    assign a = i_vars[0];
    assign b = i_vars[1];
    assign c = i_vars[2];
    assign d = i_vars[3];
    assign e = i_vars[4];
    assign f = i_vars[5];
    assign g = i_vars[6];
    assign h = i_vars[7];

    assign t1 = h + f_bsig1(e) + ((e & f) ^ (~e & g)) + i_k + w0;
    assign t2 = f_bsig0(a) + ((a & b) ^ (a & c) ^ (b & c));

    assign o_vars = {g, f, e, d + t1, c, b, a, t1 + t2};

endmodule

// File: design/sha256_stream_hasher_top.sv
// Channel   Direction  Payload                                     Moves per request
// i_req     in         data_byte, byte_present, end_of_message     one message byte or end mark
// o_dig     out        digest_word, word_number, last_word         one 32-bit digest word
//
// A byte request is taken while idle; the request that fills a 64-byte block is followed
// by a busy stretch: 64 rounds through the shared round unit, then a fold into the hash.
// An end-of-message request then feeds up to 72 padding bytes, one per cycle outside the
// one or two block compressions, and offers eight digest words, one per cycle while the sink
// accepts them. A stalled o_dig holds the word and keeps i_req not ready meanwhile.
// Reset is synchronous and active low; it restores the initial hash and clears the sequencer.
module sha256_stream_hasher_top (
    input logic            i_clk,
    input logic            i_rst_n,
    sha256_in_if.sink      i_req,
    sha256_out_if.source   o_dig
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [5:0]          r_fill, n_fill;
    logic [63:0]         r_count, n_count;
    logic [63:0]         r_len, n_len;
    logic                r_pad, n_pad;
    logic                r_pad_first, n_pad_first;
    logic                r_len_phase, n_len_phase;
    logic                r_len_done, n_len_done;
    logic [5:0]          r_round, n_round;
    logic [2:0]          r_word, n_word;
    logic [511:0]        r_win, n_win;
    sha256_pkg::t_words  r_vars, n_vars;
    sha256_pkg::t_words  r_hash, n_hash;

    sha256_pkg::t_words  round_vars;
    logic [31:0]         round_sched;
    logic                req_acc;
    logic                push;
    logic [7:0]          push_byte;

    // The one round unit: it also produces the next message schedule word.
    sha256_round u_round (
        .i_vars  (r_vars),
        .i_k     (sha256_pkg::K_ROUND[r_round]),
        .i_win   (r_win),
        .o_vars  (round_vars),
        .o_sched (round_sched)
    );

    assign i_req.ready       = (r_state == S_IDLE);
    assign req_acc           = i_req.valid && i_req.ready;

    assign o_dig.valid       = (r_state == S_OUT);
    assign o_dig.digest_word = r_hash[r_word];
    assign o_dig.word_number = r_word;
    assign o_dig.last_word   = (r_word == 3'd7);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_count     = r_count;
        n_len       = r_len;
        n_pad       = r_pad;
        n_pad_first = r_pad_first;
        n_len_phase = r_len_phase;
        n_len_done  = r_len_done;
        n_round     = r_round;
        n_word      = r_word;
        n_win       = r_win;
        n_vars      = r_vars;
        n_hash      = r_hash;
        push        = 1'b0;
        push_byte   = 8'h00;

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.byte_present) begin
                        push      = 1'b1;
                        push_byte = i_req.data_byte;
                        n_count   = r_count + 64'd8;
                    end
                    if (i_req.end_of_message) begin
                        // Latch the final bit length and start a fresh count.
                        n_len       = i_req.byte_present ? (r_count + 64'd8) : r_count;
                        n_count     = '0;
                        n_pad       = 1'b1;
                        n_pad_first = 1'b1;
                        n_len_phase = 1'b0;
                        n_len_done  = 1'b0;
                        n_state     = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // One padding byte per cycle: the marker, zeros, then the length.
                push = 1'b1;
                if (r_pad_first) begin
                    push_byte   = sha256_pkg::PAD_MARK;
                    n_pad_first = 1'b0;
                end else if (r_len_phase || (r_fill == sha256_pkg::LEN_START)) begin
                    push_byte   = r_len[63:56];
                    n_len       = {r_len[55:0], 8'h00};
                    n_len_phase = 1'b1;
                    if (r_fill == sha256_pkg::FILL_LAST) begin
                        n_len_done = 1'b1;
                    end
                end else begin
                    push_byte = 8'h00;
                end
            end
            S_ROUND: begin
                n_vars  = round_vars;
                n_win   = {r_win[479:0], round_sched};
                n_round = r_round + 6'd1;
                if (r_round == sha256_pkg::ROUND_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                for (int i = 0; i < 8; i++) begin
                    n_hash[i] = r_hash[i] + r_vars[i];
                end
                if (r_len_done) begin
                    n_state = S_OUT;
                end else if (r_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (o_dig.ready) begin
                    n_word = r_word + 3'd1;
                    if (r_word == 3'd7) begin
                        n_hash     = sha256_pkg::H_INIT;
                        n_pad      = 1'b0;
                        n_len_done = 1'b0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A byte shifts into the block window; the 64th byte starts a compression.
        if (push) begin
            n_win  = {r_win[503:0], push_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill == sha256_pkg::FILL_LAST) begin
                n_vars  = r_hash;
                n_round = '0;
                n_state = S_ROUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_count     <= '0;
            r_pad       <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_phase <= 1'b0;
            r_len_done  <= 1'b0;
            r_round     <= '0;
            r_word      <= '0;
            r_hash      <= sha256_pkg::H_INIT;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_pad       <= n_pad;
            r_pad_first <= n_pad_first;
            r_len_phase <= n_len_phase;
            r_len_done  <= n_len_done;
            r_round     <= n_round;
            r_word      <= n_word;
            r_hash      <= n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_win  <= n_win;
        r_vars <= n_vars;
    end

endmodule
